### sv/rgb565_to_bmp24_stream_assert.svh
// Assertion macros for the RGB565 to 24-bit BMP stream block.
// Included by the modules that check their own logic; relies on aclk and aresetn in scope.
`ifndef RGB565_TO_BMP24_STREAM_ASSERT_SVH
`define RGB565_TO_BMP24_STREAM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define R2B24_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define R2B24_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/r2b24_pkg.sv
// Shared types, constants and header helpers for the RGB565 to BMP stream block.
// No dependencies.
`default_nettype none

package r2b24_pkg;

    localparam int unsigned MAX_WIDTH    = 4096;
    localparam int unsigned HEIGHT_LIMIT = 4096;
    localparam int unsigned HEADER_BYTES = 54;

    localparam logic [5:0]  HDR_LAST_IDX = 6'(HEADER_BYTES - 1);

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Image geometry after clamping
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
    } dims_t;

    // Values the header needs beyond the geometry
    typedef struct packed {
        logic [26:0] img_bytes;
        logic [26:0] file_size;
    } sizes_t;

    // One classified request between front and back
    typedef struct packed {
        logic [15:0] pixel;
        logic        hdr;
        logic [1:0]  pad;
        logic        img_end;
    } item_t;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] lim);
        logic [12:0] r;
        r = v;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > lim) begin
            r = lim;
        end
        return r;
    endfunction

    // One byte of the 54-byte file and info header.
    function automatic logic [7:0] header_byte(input logic [5:0] idx, input dims_t dims,
                                               input sizes_t sizes);
        logic [31:0] fs32;
        logic [31:0] im32;
        logic [31:0] w32;
        logic [31:0] h32;
        logic [7:0]  b;
        fs32 = {5'd0, sizes.file_size};
        im32 = {5'd0, sizes.img_bytes};
        w32  = {19'd0, dims.width};
        h32  = {19'd0, dims.height};
        unique case (idx)
            6'd0:    b = 8'h42;
            6'd1:    b = 8'h4D;
            6'd2:    b = fs32[7:0];
            6'd3:    b = fs32[15:8];
            6'd4:    b = fs32[23:16];
            6'd5:    b = fs32[31:24];
            6'd10:   b = 8'(HEADER_BYTES);
            6'd14:   b = 8'd40;
            6'd18:   b = w32[7:0];
            6'd19:   b = w32[15:8];
            6'd20:   b = w32[23:16];
            6'd21:   b = w32[31:24];
            6'd22:   b = h32[7:0];
            6'd23:   b = h32[15:8];
            6'd24:   b = h32[23:16];
            6'd25:   b = h32[31:24];
            6'd26:   b = 8'd1;
            6'd28:   b = 8'd24;
            6'd34:   b = im32[7:0];
            6'd35:   b = im32[15:8];
            6'd36:   b = im32[23:16];
            6'd37:   b = im32[31:24];
            6'd38:   b = 8'h13;
            6'd39:   b = 8'h0B;
            6'd42:   b = 8'h13;
            6'd43:   b = 8'h0B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### sv/r2b24_front.sv
// Front end: accepts pixels, tracks row and column, tags header, padding and image end.
// Depends on r2b24_pkg.
`default_nettype none

module r2b24_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [15:0]      s_pixel_rgb565,
    input  wire r2b24_pkg::dims_t dims,
    input  wire logic             queue_full,
    output logic                  push,
    output r2b24_pkg::item_t      item
);

    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        row_end;
    logic        img_end;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    assign col_inc = {1'b0, col_reg} + 13'd1;
    assign row_inc = {1'b0, row_reg} + 13'd1;
    assign row_end = (col_inc >= dims.width);
    assign img_end = row_end && (row_inc >= dims.height);

    always_comb begin
        item.pixel   = s_pixel_rgb565;
        item.hdr     = (col_reg == 12'd0) && (row_reg == 12'd0);
        item.pad     = row_end ? dims.width[1:0] : 2'd0;
        item.img_end = img_end;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (row_end) begin
                col_next = 12'd0;
                row_next = img_end ? 12'd0 : row_inc[11:0];
            end else begin
                col_next = col_inc[11:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 12'd0;
            row_reg <= 12'd0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### sv/r2b24_fifo.sv
// Four-entry request queue between the front and back ends.
// Depends on r2b24_pkg.
`default_nettype none

module r2b24_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire r2b24_pkg::item_t  push_item,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output r2b24_pkg::item_t       head
);

    r2b24_pkg::item_t entries_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       do_pop;

    assign full       = (count_reg == 3'd4);
    assign head_valid = (count_reg != 3'd0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'd0, push} - {2'd0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/r2b24_back.sv
// Back end: walks header, pixel and padding bytes of the queue head into the output register.
// Depends on r2b24_pkg and rgb565_to_bmp24_stream_assert.svh.
`default_nettype none
`include "rgb565_to_bmp24_stream_assert.svh"

module r2b24_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  wire r2b24_pkg::item_t  head,
    output logic                   pop,
    input  wire r2b24_pkg::dims_t  dims,
    input  wire r2b24_pkg::sizes_t sizes,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_last_of_run,
    output logic                   m_image_done
);

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_BLUE   = 6'b000100,
        PH_GREEN  = 6'b001000,
        PH_RED    = 6'b010000,
        PH_PAD    = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [5:0]  cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic        emit;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;
    logic [1:0]  pad_last;

    assign r5 = head.pixel[15:11];
    assign g6 = head.pixel[10:5];
    assign b5 = head.pixel[4:0];
    assign pad_last = head.pad - 2'd1;

    assign emit = head_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (phase_reg == PH_START) begin
            cur_phase = head.hdr ? PH_HEADER : PH_BLUE;
        end else begin
            cur_phase = phase_reg;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        byte_next  = byte_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (emit) begin
            byte_next = 8'h00;
            last_next = 1'b0;
            done_next = 1'b0;
            unique case (cur_phase)
                PH_HEADER: begin
                    byte_next = r2b24_pkg::header_byte(cnt_reg, dims, sizes);
                    if (cnt_reg == r2b24_pkg::HDR_LAST_IDX) begin
                        phase_next = PH_BLUE;
                        cnt_next   = 6'd0;
                    end else begin
                        phase_next = PH_HEADER;
                        cnt_next   = cnt_reg + 6'd1;
                    end
                end
                PH_BLUE: begin
                    byte_next  = {b5, b5[4:2]};
                    phase_next = PH_GREEN;
                end
                PH_GREEN: begin
                    byte_next  = {g6, g6[5:4]};
                    phase_next = PH_RED;
                end
                PH_RED: begin
                    byte_next = {r5, r5[4:2]};
                    cnt_next  = 6'd0;
                    if (head.pad == 2'd0) begin
                        last_next  = 1'b1;
                        done_next  = head.img_end;
                        pop        = 1'b1;
                        phase_next = PH_START;
                    end else begin
                        phase_next = PH_PAD;
                    end
                end
                PH_PAD: begin
                    if (cnt_reg[1:0] == pad_last) begin
                        last_next  = 1'b1;
                        done_next  = head.img_end;
                        pop        = 1'b1;
                        phase_next = PH_START;
                        cnt_next   = 6'd0;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
                default: begin
                    phase_next = PH_START;
                    cnt_next   = 6'd0;
                end
            endcase
        end
    end

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            cnt_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;
    assign m_image_done  = done_reg;

    `R2B24_CHECK(a_done_is_last, m_valid_reg && done_reg, last_reg, "image end off a run end")
    `R2B24_CHECK(a_hdr_cnt_range, phase_reg == PH_HEADER, cnt_reg <= r2b24_pkg::HDR_LAST_IDX, "header index out of range")
    `R2B24_CHECK(a_pop_has_head, pop, head_valid, "pop from empty queue")
    `R2B24_CHECK_NEXT(a_hdr_to_blue, emit && (cur_phase == PH_HEADER) && (cnt_reg == r2b24_pkg::HDR_LAST_IDX), phase_reg == PH_BLUE, "header did not hand over to pixel")

endmodule

`default_nettype wire

### sv/rgb565_to_bmp24_stream.sv
// RGB565 pixel stream in, 24-bit BMP byte stream out. One byte leaves per cycle through the
// output register while m_ready is high and a request waits. A plain pixel gives B, G, R; an
// image's first pixel adds the 54-byte file and info header, and a row's last pixel adds width
// mod 4 zero padding bytes. A new pixel request is taken while earlier ones still drain, as
// long as the four-entry queue between the front end (row/column tracking) and the back end
// (byte sequencer) has room. Width and height are clamped to 1..4096; write them only while
// idle. Taking an image's last pixel zeroes the counters; the next pixel opens a new image.
// Depends on r2b24_pkg, r2b24_front, r2b24_fifo and r2b24_back.
`default_nettype none

module rgb565_to_bmp24_stream (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [12:0] cfg_wr_data,
    // pixel requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_pixel_rgb565,
    // byte results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_of_run,
    output logic             m_image_done
);

    logic [12:0]          width_reg, width_next;
    logic [12:0]          height_reg, height_next;
    r2b24_pkg::dims_t     dims;
    r2b24_pkg::sizes_t    sizes;
    logic [14:0]          row_sum;
    logic [13:0]          row_bytes;
    logic [26:0]          img_bytes_reg, img_bytes_next;
    logic [26:0]          file_size_reg, file_size_next;
    logic                 push;
    logic                 queue_full;
    logic                 pop;
    logic                 head_valid;
    r2b24_pkg::item_t     push_item;
    r2b24_pkg::item_t     head;

    // Register writes: take effect at once, on the next pixel.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                r2b24_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wr_data;
                r2b24_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wr_data;
                default: begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd320;
            height_reg <= 13'd240;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Clamp the geometry to what the header reports.
    assign dims.width  = r2b24_pkg::clamp_dim(width_reg, 13'(r2b24_pkg::MAX_WIDTH));
    assign dims.height = r2b24_pkg::clamp_dim(height_reg, 13'(r2b24_pkg::HEIGHT_LIMIT));

    // Row length in bytes: 3*width rounded up to a multiple of four.
    assign row_sum   = {dims.width, 1'b0} + {2'd0, dims.width} + 15'd3;
    assign row_bytes = {row_sum[13:2], 2'b00};

    // Hold image and file size in registers, the multiply in img_bytes_reg and the add behind it
    // in file_size_reg; both settle well before the header reaches those bytes after a write.
    assign img_bytes_next = {13'd0, row_bytes} * {14'd0, dims.height};
    assign file_size_next = img_bytes_reg + 27'(r2b24_pkg::HEADER_BYTES);

    always_ff @(posedge aclk) begin
        img_bytes_reg <= img_bytes_next;
        file_size_reg <= file_size_next;
    end

    assign sizes.img_bytes = img_bytes_reg;
    assign sizes.file_size = file_size_reg;

    // Front end: classify each pixel request and advance the counters.
    r2b24_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_rgb565 (s_pixel_rgb565),
        .dims           (dims),
        .queue_full     (queue_full),
        .push           (push),
        .item           (push_item)
    );

    // Queue: lets the front keep taking requests while bytes drain.
    r2b24_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: one byte per cycle into the output register, while m_ready and the queue allow.
    r2b24_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .dims          (dims),
        .sizes         (sizes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_image_done  (m_image_done)
    );

endmodule

`default_nettype wire
